// ----- src/dfa_state_minimizer_top_defines.svh -----
// Assertion macros shared by the minimiser RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DFA_STATE_MINIMIZER_TOP_DEFINES_SVH
`define DFA_STATE_MINIMIZER_TOP_DEFINES_SVH

// Implication checked in the same cycle.
`define DSM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsm: same-cycle check failed");

// Implication checked in the next cycle.
`define DSM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsm: next-cycle check failed");

`endif

// ----- src/dsm_pkg.sv -----
// Shared types and constants of the DFA state minimiser.
// Used by the controller, the datapath and the top level; no dependencies.
package dsm_pkg;

  localparam int DEF_MAX_STATES  = 32;
  localparam int DEF_MAX_SYMBOLS = 16;

  // Widths fixed by the item and register fields.
  localparam int STATE_W   = 5;
  localparam int SYM_W     = 4;
  localparam int CNT_W     = 6;
  localparam int SCNT_W    = 5;
  localparam int ENTRY_W   = 6;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 1'd1;

  localparam logic [CNT_W-1:0]  STATE_COUNT_RST  = 6'd32;
  localparam logic [SCNT_W-1:0] SYMBOL_COUNT_RST = 5'd16;

  // Which index drives the class array read port.
  typedef enum logic [1:0] {
    SEL_S,
    SEL_T,
    SEL_D
  } cls_sel_t;

  typedef struct packed {
    logic     clr_wr;
    logic     load_en;
    logic     init;
    logic     s_clr;
    logic     s_inc;
    logic     grew_clr;
    logic     reach_set;
    logic     a_clr;
    logic     a_inc;
    logic     rd_s;
    logic     rd_t;
    logic     part_init;
    logic     k_clr;
    logic     cs_load;
    logic     t_clr;
    logic     t_inc;
    logic     nxt_new;
    logic     nxt_copy;
    logic     ts_load;
    logic     pass_end;
    logic     out_load;
    logic     acc_clr;
    cls_sel_t cls_sel;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic last_accept;
    logic s_end;
    logic s_reach;
    logic s_last;
    logic t_eq_s;
    logic t_reach;
    logic a_end;
    logic cls_eq;
    logic sig_eq;
    logic grew;
    logic k_ne_prev;
    logic out_free;
  } status_t;

endpackage

// ----- src/dfa_state_minimizer_top.sv -----
// Top level of the DFA state minimiser.
// Instantiates dsm_ctrl and dsm_datapath; depends on dsm_pkg.
//
// Usage: configure state_count and symbol_count through the write port
// (cfg_we, cfg_index, cfg_data) while the block is idle. Transition entries
// arrive on the input channel (in_valid/in_stall), one transfer per cycle
// while loading. The entry with load_last set starts minimisation; input is
// stalled from then until the next DFA may be loaded.
// Minimisation walks the move table through its single registered read port:
// reachability passes repeat until no new state is reached, and each
// refinement pass compares every reachable state with its lower reachable
// states of the same class, symbol by symbol, until one matches.
// Results, one per state in use, leave on the output channel
// (out_valid/out_stall) through an output register, at most one per cycle;
// a stalled receiver holds the current result and pauses emission.
// After reset, and after each DFA is emitted, the move table is swept clear,
// one entry per cycle across all MAX_STATES*MAX_SYMBOLS entries, before loading is
// accepted again. Configuration keeps its value across minimisations.
module dfa_state_minimizer_top #(
  parameter int MAX_STATES  = dsm_pkg::DEF_MAX_STATES,
  parameter int MAX_SYMBOLS = dsm_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dsm_pkg::STATE_W-1:0]   src_state,
  input  logic [dsm_pkg::SYM_W-1:0]     sym,
  input  logic [dsm_pkg::STATE_W-1:0]   dst_state,
  input  logic                          has_move,
  input  logic                          is_accepting,
  input  logic                          load_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsm_pkg::STATE_W-1:0]   orig_state,
  output logic                          reachable,
  output logic [dsm_pkg::STATE_W-1:0]   class_id,
  output logic                          class_accepts,
  output logic [dsm_pkg::CNT_W-1:0]     class_total,
  output logic                          emit_last
);
  import dsm_pkg::*;

  cmd_t    cmd;
  status_t st;

  dsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  dsm_datapath #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .src_state     (src_state),
    .sym           (sym),
    .dst_state     (dst_state),
    .has_move      (has_move),
    .is_accepting  (is_accepting),
    .load_last     (load_last),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .orig_state    (orig_state),
    .reachable     (reachable),
    .class_id      (class_id),
    .class_accepts (class_accepts),
    .class_total   (class_total),
    .emit_last     (emit_last),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

// ----- src/dsm_ctrl.sv -----
// Sequencer of the DFA state minimiser: clearing, loading, reachability,
// partition refinement and emission. Depends on dsm_pkg.
module dsm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  dsm_pkg::status_t  st,
  output dsm_pkg::cmd_t     cmd,
  output logic              in_stall
);
  import dsm_pkg::*;

  typedef enum logic [3:0] {
    CLEAR, LOAD, INIT, R_S, R_A, R_D, P_INIT,
    F_INIT, F_S, F_T, F_A, F_SD, F_TD, EMIT_INIT, EMIT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != LOAD);

  always_comb begin
    cmd        = '0;
    cmd.cls_sel = SEL_S;
    state_next = state;
    case (state)
      CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_done) state_next = LOAD;
      end
      LOAD: begin
        cmd.load_en = 1'b1;
        if (st.last_accept) state_next = INIT;
      end
      INIT: begin
        cmd.init   = 1'b1;
        state_next = R_S;
      end
      R_S: begin
        if (st.s_end) begin
          if (st.grew) begin
            cmd.grew_clr = 1'b1;
            cmd.s_clr    = 1'b1;
          end else begin
            state_next = P_INIT;
          end
        end else if (!st.s_reach) begin
          cmd.s_inc = 1'b1;
        end else begin
          cmd.a_clr  = 1'b1;
          state_next = R_A;
        end
      end
      R_A: begin
        if (st.a_end) begin
          cmd.s_inc  = 1'b1;
          state_next = R_S;
        end else begin
          cmd.rd_s   = 1'b1;
          state_next = R_D;
        end
      end
      R_D: begin
        cmd.reach_set = 1'b1;
        cmd.a_inc     = 1'b1;
        state_next    = R_A;
      end
      P_INIT: begin
        cmd.part_init = 1'b1;
        state_next    = F_INIT;
      end
      F_INIT: begin
        cmd.s_clr  = 1'b1;
        cmd.k_clr  = 1'b1;
        state_next = F_S;
      end
      F_S: begin
        cmd.cls_sel = SEL_S;
        if (st.s_end) begin
          cmd.pass_end = 1'b1;
          state_next   = st.k_ne_prev ? F_INIT : EMIT_INIT;
        end else if (!st.s_reach) begin
          cmd.s_inc = 1'b1;
        end else begin
          cmd.cs_load = 1'b1;
          cmd.t_clr   = 1'b1;
          state_next  = F_T;
        end
      end
      F_T: begin
        cmd.cls_sel = SEL_T;
        if (st.t_eq_s) begin
          cmd.nxt_new = 1'b1;
          cmd.s_inc   = 1'b1;
          state_next  = F_S;
        end else if (!st.t_reach || !st.cls_eq) begin
          cmd.t_inc = 1'b1;
        end else begin
          cmd.a_clr  = 1'b1;
          state_next = F_A;
        end
      end
      F_A: begin
        if (st.a_end) begin
          cmd.nxt_copy = 1'b1;
          cmd.s_inc    = 1'b1;
          state_next   = F_S;
        end else begin
          cmd.rd_s   = 1'b1;
          state_next = F_SD;
        end
      end
      F_SD: begin
        cmd.cls_sel = SEL_D;
        cmd.ts_load = 1'b1;
        cmd.rd_t    = 1'b1;
        state_next  = F_TD;
      end
      F_TD: begin
        cmd.cls_sel = SEL_D;
        if (st.sig_eq) begin
          cmd.a_inc  = 1'b1;
          state_next = F_A;
        end else begin
          cmd.t_inc  = 1'b1;
          state_next = F_T;
        end
      end
      EMIT_INIT: begin
        cmd.s_clr  = 1'b1;
        state_next = EMIT;
      end
      EMIT: begin
        cmd.cls_sel = SEL_S;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.s_last) begin
            cmd.acc_clr = 1'b1;
            state_next  = CLEAR;
          end else begin
            cmd.s_inc = 1'b1;
          end
        end
      end
      default: state_next = CLEAR;
    endcase
  end

endmodule

// ----- src/dsm_datapath.sv -----
// Datapath of the DFA state minimiser: move table memory, accept, reach and
// class arrays, loop counters and the output register. Depends on dsm_pkg.
`include "dfa_state_minimizer_top_defines.svh"
module dsm_datapath #(
  parameter int MAX_STATES  = dsm_pkg::DEF_MAX_STATES,
  parameter int MAX_SYMBOLS = dsm_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic [dsm_pkg::STATE_W-1:0]   src_state,
  input  logic [dsm_pkg::SYM_W-1:0]     sym,
  input  logic [dsm_pkg::STATE_W-1:0]   dst_state,
  input  logic                          has_move,
  input  logic                          is_accepting,
  input  logic                          load_last,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [dsm_pkg::STATE_W-1:0]   orig_state,
  output logic                          reachable,
  output logic [dsm_pkg::STATE_W-1:0]   class_id,
  output logic                          class_accepts,
  output logic [dsm_pkg::CNT_W-1:0]     class_total,
  output logic                          emit_last,
  input  dsm_pkg::cmd_t                 cmd,
  output dsm_pkg::status_t              st
);
  import dsm_pkg::*;

  localparam int DEPTH = MAX_STATES * MAX_SYMBOLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(MAX_STATES);
  localparam int NLIM  = (MAX_STATES < 32) ? MAX_STATES : 32;
  localparam int MLIM  = (MAX_SYMBOLS < 16) ? MAX_SYMBOLS : 16;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata;

  logic [CNT_W-1:0]  state_count;
  logic [SCNT_W-1:0] symbol_count;
  logic [CNT_W-1:0]  n, n_next;
  logic [SCNT_W-1:0] m, m_next;
  logic              mode;

  logic [AW-1:0]     clr_addr;
  logic [CNT_W-1:0]  s, t, k, prev;
  logic [SCNT_W-1:0] a;
  logic              grew;

  logic [MAX_STATES-1:0] acc, reach;
  logic [SW-1:0]         cls [MAX_STATES];
  logic [SW-1:0]         nxt [MAX_STATES];
  logic [SW-1:0]         cs;
  logic [SW:0]           ts, tcls;

  logic              in_accept, tgt_ok;
  logic [SW-1:0]     d_idx, cls_idx, cls_rd;
  logic [AW-1:0]     waddr, raddr;
  logic [ENTRY_W-1:0] wdata;
  logic              wen, in_table;
  logic [SCNT_W-1:0] a_lim;

  assign in_accept = in_valid && cmd.load_en;
  assign in_table  = (32'(src_state) < MAX_STATES) && (32'(sym) < MAX_SYMBOLS);

  always_comb begin
    if (cmd.clr_wr) begin
      waddr = clr_addr;
      wdata = '0;
      wen   = 1'b1;
    end else begin
      waddr = AW'(32'(src_state) * MAX_SYMBOLS + 32'(sym));
      wdata = has_move ? {1'b1, dst_state} : '0;
      wen   = in_accept && in_table;
    end
  end

  assign raddr = AW'(32'(cmd.rd_t ? t : s) * MAX_SYMBOLS + 32'(a));

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    if (cmd.rd_s || cmd.rd_t) rdata <= mem[raddr];
  end

  // A stored target at or beyond the state count behaves as a missing move.
  assign tgt_ok = rdata[ENTRY_W-1] && ({1'b0, rdata[STATE_W-1:0]} < n);
  assign d_idx  = SW'(rdata[STATE_W-1:0]);

  always_comb begin
    case (cmd.cls_sel)
      SEL_S:   cls_idx = s[SW-1:0];
      SEL_T:   cls_idx = t[SW-1:0];
      default: cls_idx = d_idx;
    endcase
  end
  assign cls_rd = cls[cls_idx];
  assign tcls   = tgt_ok ? {1'b1, cls_rd} : '0;

  always_comb begin
    if (state_count == '0) begin
      n_next = CNT_W'(1);
    end else if (32'(state_count) > NLIM) begin
      n_next = CNT_W'(NLIM);
    end else begin
      n_next = state_count;
    end
    m_next = (32'(symbol_count) > MLIM) ? SCNT_W'(MLIM) : symbol_count;
  end

  assign a_lim = mode ? m : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count  <= STATE_COUNT_RST;
      symbol_count <= SYMBOL_COUNT_RST;
      clr_addr     <= '0;
      acc          <= '0;
      reach        <= '0;
      n            <= CNT_W'(1);
      m            <= '0;
      mode         <= 1'b1;
      s            <= '0;
      t            <= '0;
      a            <= '0;
      k            <= '0;
      prev         <= '0;
      grew         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STATE_COUNT:  state_count  <= cfg_data;
          REG_SYMBOL_COUNT: symbol_count <= cfg_data[SCNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_wr) begin
        clr_addr <= st.clr_done ? '0 : clr_addr + AW'(1);
      end
      if (in_accept && is_accepting && (32'(src_state) < MAX_STATES)) begin
        acc[SW'(src_state)] <= 1'b1;
      end
      if (cmd.acc_clr) acc <= '0;
      if (cmd.init) begin
        n     <= n_next;
        m     <= m_next;
        mode  <= 1'b1;
        reach <= MAX_STATES'(1);
        grew  <= 1'b0;
        s     <= '0;
        k     <= '0;
      end
      if (cmd.grew_clr) grew <= 1'b0;
      if (cmd.reach_set && tgt_ok && !reach[d_idx]) begin
        reach[d_idx] <= 1'b1;
        grew         <= 1'b1;
      end
      if (cmd.s_clr) s <= '0;
      if (cmd.s_inc) s <= s + CNT_W'(1);
      if (cmd.t_clr) t <= '0;
      if (cmd.t_inc) t <= t + CNT_W'(1);
      if (cmd.a_clr) a <= '0;
      if (cmd.a_inc) a <= a + SCNT_W'(1);
      if (cmd.part_init) begin
        prev <= '0;
        mode <= 1'b0;
      end
      if (cmd.k_clr)   k <= '0;
      if (cmd.nxt_new) k <= k + CNT_W'(1);
      if (cmd.pass_end) begin
        prev <= k;
        mode <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Class arrays and per-pass registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.part_init) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        cls[i] <= SW'(acc[i]);
      end
    end
    if (cmd.pass_end) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        cls[i] <= nxt[i];
      end
    end
    if (cmd.cs_load)  cs <= cls_rd;
    if (cmd.ts_load)  ts <= tcls;
    if (cmd.nxt_new)  nxt[s[SW-1:0]] <= k[SW-1:0];
    if (cmd.nxt_copy) nxt[s[SW-1:0]] <= nxt[t[SW-1:0]];
    if (cmd.out_load) begin
      orig_state    <= STATE_W'(s);
      reachable     <= reach[s[SW-1:0]];
      class_id      <= reach[s[SW-1:0]] ? STATE_W'(cls_rd) : '0;
      class_accepts <= reach[s[SW-1:0]] && acc[s[SW-1:0]];
      class_total   <= prev;
      emit_last     <= (s + CNT_W'(1) == n);
    end
  end

  always_comb begin
    st.clr_done    = (clr_addr == AW'(DEPTH - 1));
    st.last_accept = in_accept && load_last;
    st.s_end       = (s == n);
    st.s_reach     = reach[s[SW-1:0]];
    st.s_last      = (s + CNT_W'(1) == n);
    st.t_eq_s      = (t == s);
    st.t_reach     = reach[t[SW-1:0]];
    st.a_end       = (a == a_lim);
    st.cls_eq      = (cls_rd == cs);
    st.sig_eq      = (tcls == ts);
    st.grew        = grew;
    st.k_ne_prev   = (k != prev);
    st.out_free    = !out_valid || !out_stall;
  end

  `DSM_ASSERT_IMP(a_pass_refines, cmd.pass_end, k >= prev)
  `DSM_ASSERT_IMP(a_class_bound, cmd.nxt_new, k < n)
  `DSM_ASSERT_IMP(a_out_free, cmd.out_load, !out_valid || !out_stall)
  `DSM_ASSERT_NXT(a_root_reached, cmd.init, reach[0])

endmodule
